// ===== hdl/mst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants for the multi-touch slot tracker
// Event type and code values of the slot protocol, output field widths and
// the sequencer state type.
// ----------------------------------------------------------------------------
package mst_pkg;

    // Event types
    localparam logic [15:0] TYPE_SYN = 16'h0000;
    localparam logic [15:0] TYPE_ABS = 16'h0003;

    // Absolute-axis codes
    localparam logic [15:0] CODE_SLOT = 16'h002f;
    localparam logic [15:0] CODE_X    = 16'h0035;
    localparam logic [15:0] CODE_Y    = 16'h0036;
    localparam logic [15:0] CODE_ID   = 16'h0039;

    // Sync codes
    localparam logic [15:0] SYNC_REPORT  = 16'h0000;
    localparam logic [15:0] SYNC_DROPPED = 16'h0003;

    // Tracking id of an empty slot
    localparam logic [31:0] ID_EMPTY = 32'hffff_ffff;

    // Output field widths
    localparam int SLOT_NUM_W = 3;
    localparam int COUNT_W    = 4;

    // Frame sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PUSH
    } state_t;

endpackage : mst_pkg
`default_nettype wire

// ===== hdl/multitouch_slot_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multitouch_slot_tracker: type-B multi-touch slot tracker
// Keeps tracking id, X and Y for each slot, updated by absolute-axis events,
// and walks all slots to emit one frame word per slot on a sync report or dropped marker.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    event_type, event_code, event_value
// out      output     out_valid/out_ready  slot_number, finger_id, pos_x,
//                                          pos_y, active_count, after_drop,
//                                          frame_last
//
// Axis and ignored events leave the sequencer idle. A report or dropped
// marker moves it to a fetch state that primes the slot memory read and
// then to a push state that loads the slot words one at a time through
// the single read address of the slot memory. in_ready stays low while a
// frame is being walked; a stall on out holds the walk. Reset marks every
// slot empty at once through per-entry valid bits; a dropped marker does
// the same when it is accepted.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [15:0]                     event_type,
    input  wire logic [15:0]                     event_code,
    input  wire logic signed [31:0]              event_value,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [mst_pkg::SLOT_NUM_W-1:0]       slot_number,
    output logic signed [31:0]                   finger_id,
    output logic [31:0]                          pos_x,
    output logic [31:0]                          pos_y,
    output logic [mst_pkg::COUNT_W-1:0]          active_count,
    output logic                                 after_drop,
    output logic                                 frame_last
);
    import mst_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
    localparam logic [31:0]   SLOT_LIMIT = 32'(NUM_SLOTS);

    // Slot storage, reset through valid bits
    logic [31:0] id_mem [NUM_SLOTS];
    logic [31:0] x_mem  [NUM_SLOTS];
    logic [31:0] y_mem  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] id_vld_reg, x_vld_reg, y_vld_reg;
    logic [NUM_SLOTS-1:0] id_vld_next, x_vld_next, y_vld_next;

    // Active flags and running count
    logic [NUM_SLOTS-1:0] act_reg, act_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    logic [IW-1:0] sel_reg, sel_next;

    // Sequencer
    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] rd_addr;
    logic          drop_reg, drop_next;
    logic          load;

    // Registered read data
    logic [31:0] rd_id_reg, rd_x_reg, rd_y_reg;
    logic        rd_idv_reg, rd_xv_reg, rd_yv_reg;

    // Output word
    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_NUM_W-1:0] slot_number_reg;
    logic [31:0]           finger_id_reg, pos_x_reg, pos_y_reg;
    logic [COUNT_W-1:0]    active_count_reg;
    logic                  after_drop_reg, frame_last_reg;

    logic in_acc;
    logic is_abs, is_report, is_drop;
    logic wr_id, wr_x, wr_y;
    logic new_act;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;

    // Event decode
    assign is_abs    = (event_type == TYPE_ABS);
    assign is_report = (event_type == TYPE_SYN) && (event_code == SYNC_REPORT);
    assign is_drop   = (event_type == TYPE_SYN) && (event_code == SYNC_DROPPED);
    assign wr_id     = in_acc && is_abs && (event_code == CODE_ID);
    assign wr_x      = in_acc && is_abs && (event_code == CODE_X);
    assign wr_y      = in_acc && is_abs && (event_code == CODE_Y);
    assign new_act   = ~event_value[31];

    // Slot state updates
    always_comb
    begin
        sel_next    = sel_reg;
        id_vld_next = id_vld_reg;
        x_vld_next  = x_vld_reg;
        y_vld_next  = y_vld_reg;
        act_next    = act_reg;
        cnt_next    = cnt_reg;
        if (in_acc && is_abs && (event_code == CODE_SLOT))
        begin
            if (event_value < SLOT_LIMIT)
                sel_next = event_value[IW-1:0];
            else
                sel_next = '0;
        end
        if (wr_id)
        begin
            id_vld_next[sel_reg] = 1'b1;
            act_next[sel_reg]    = new_act;
            // keep the count in step with the flag change
            if (act_reg[sel_reg] && !new_act)
                cnt_next = cnt_reg - CW'(1);
            else if (!act_reg[sel_reg] && new_act)
                cnt_next = cnt_reg + CW'(1);
        end
        if (wr_x)
            x_vld_next[sel_reg] = 1'b1;
        if (wr_y)
            y_vld_next[sel_reg] = 1'b1;
        if (in_acc && is_drop)
        begin
            id_vld_next = '0;
            x_vld_next  = '0;
            y_vld_next  = '0;
            act_next    = '0;
            cnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg    <= '0;
            id_vld_reg <= '0;
            x_vld_reg  <= '0;
            y_vld_reg  <= '0;
            act_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            sel_reg    <= sel_next;
            id_vld_reg <= id_vld_next;
            x_vld_reg  <= x_vld_next;
            y_vld_reg  <= y_vld_next;
            act_reg    <= act_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Slot memory: write port on axis events, registered read for frames
    always_ff @(posedge clk)
    begin
        if (wr_id)
            id_mem[sel_reg] <= event_value;
        if (wr_x)
            x_mem[sel_reg] <= event_value;
        if (wr_y)
            y_mem[sel_reg] <= event_value;
        rd_id_reg  <= id_mem[rd_addr];
        rd_x_reg   <= x_mem[rd_addr];
        rd_y_reg   <= y_mem[rd_addr];
        rd_idv_reg <= id_vld_reg[rd_addr];
        rd_xv_reg  <= x_vld_reg[rd_addr];
        rd_yv_reg  <= y_vld_reg[rd_addr];
    end

    // Frame sequencer: next state and output word load
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        drop_next      = drop_reg;
        load           = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        rd_addr        = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (is_report || is_drop))
                begin
                    state_next = ST_FETCH;
                    idx_next   = '0;
                    drop_next  = is_drop;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                        rd_addr  = idx_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word, unwritten entries read as their reset value
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_number_reg  <= SLOT_NUM_W'(idx_reg);
            finger_id_reg    <= rd_idv_reg ? rd_id_reg : ID_EMPTY;
            pos_x_reg        <= rd_xv_reg ? rd_x_reg : 32'd0;
            pos_y_reg        <= rd_yv_reg ? rd_y_reg : 32'd0;
            active_count_reg <= COUNT_W'(cnt_reg);
            after_drop_reg   <= drop_reg;
            frame_last_reg   <= (idx_reg == LAST_IDX);
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_number  = slot_number_reg;
    assign finger_id    = finger_id_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign active_count = active_count_reg;
    assign after_drop   = after_drop_reg;
    assign frame_last   = frame_last_reg;

`ifndef ASSERT_OFF
    // Running count matches the active flags
    a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(act_reg) == 32'(cnt_reg))
        else $error("active count out of step with slot flags");

    // A frame after a drop shows no active slot
    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && after_drop) |-> (active_count == '0))
        else $error("dropped frame reports active slots");

    // A report or drop starts the frame walk
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (is_report || is_drop)) |=> (state_reg == ST_FETCH))
        else $error("frame walk did not start");

    // The last word of a frame names the last slot
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> (slot_number == SLOT_NUM_W'(NUM_SLOTS - 1)))
        else $error("frame end on wrong slot");
`endif

endmodule : multitouch_slot_tracker
`default_nettype wire

// ===== sim/multitouch_slot_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_tb: self-checking bench for the slot tracker
// Feeds touch events through the valid/ready input channel and tracks slot
// state alongside the block to predict every frame word. Each word taken
// from the output channel is checked against the oldest prediction. Random
// idle and stall mixes, one long output hold and drain pauses are included.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker_tb;
    import mst_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int SLOTS        = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_EVENTS = 95;
    localparam int MAX_SHOWN    = 10;

    // Codes the block has to ignore
    localparam logic [15:0] SYN_MT_MARK = 16'h0002;
    localparam logic [15:0] CODE_OTHER  = 16'h0030;
    localparam logic [15:0] TYPE_KEY    = 16'h0001;

    typedef enum logic [1:0] {
        KIND_EVENT,
        KIND_MODE,
        KIND_HOLD,
        KIND_DRAIN
    } feed_kind_t;

    typedef struct {
        feed_kind_t  kind;
        logic [15:0] ev_type;
        logic [15:0] ev_code;
        logic [31:0] ev_value;
        int          idle_pct;
        int          stall_pct;
    } feed_item_t;

    typedef struct packed {
        logic [SLOT_NUM_W-1:0] slot;
        logic [31:0]           id;
        logic [31:0]           x;
        logic [31:0]           y;
        logic [COUNT_W-1:0]    count;
        logic                  drop;
        logic                  last;
    } frame_word_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [15:0]           event_type  = '0;
    logic [15:0]           event_code  = '0;
    logic signed [31:0]    event_value = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic signed [31:0]    finger_id;
    logic [31:0]           pos_x;
    logic [31:0]           pos_y;
    logic [COUNT_W-1:0]    active_count;
    logic                  after_drop;
    logic                  frame_last;

    // Pending input words and predicted frame words
    feed_item_t  event_feed[$];
    frame_word_t frame_words_due[$];

    // Shadow of the slot state
    logic [2:0]  cur_slot;
    logic [31:0] slot_id[SLOTS];
    logic [31:0] slot_x[SLOTS];
    logic [31:0] slot_y[SLOTS];

    logic in_fire        = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_requests  = 0;
    int   hold_seen      = 0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;
    int   events_queued  = 0;
    int   events_taken   = 0;
    int   words_checked  = 0;
    int   mismatches     = 0;
    int   reports        = 0;
    int   drops          = 0;
    int   wrapped        = 0;
    int   ignored        = 0;

    multitouch_slot_tracker #(
        .NUM_SLOTS(SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slot_number (slot_number),
        .finger_id   (finger_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .active_count(active_count),
        .after_drop  (after_drop),
        .frame_last  (frame_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stimulus queue helpers
    function automatic void push_event(input logic [15:0] t, input logic [15:0] c,
                                       input logic [31:0] v);
        feed_item_t item;
        item = '{KIND_EVENT, t, c, v, 0, 0};
        event_feed.push_back(item);
        events_queued++;
    endfunction

    function automatic void push_ctrl(input feed_kind_t kind, input int idle_pct,
                                      input int stall_pct);
        feed_item_t item;
        item = '{kind, '0, '0, '0, idle_pct, stall_pct};
        event_feed.push_back(item);
    endfunction

    // Snapshot all slots into one frame, slot 0 first
    function automatic void queue_frame(input logic drop);
        frame_word_t w;
        logic [COUNT_W-1:0] live;
        live = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_id[i][31])
                live++;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            w.slot  = SLOT_NUM_W'(i);
            w.id    = slot_id[i];
            w.x     = slot_x[i];
            w.y     = slot_y[i];
            w.count = live;
            w.drop  = drop;
            w.last  = (i == SLOTS - 1);
            frame_words_due.push_back(w);
        end
    endfunction

    // Slot protocol: update the shadow state, predict any frame
    function automatic void track_event(input logic [15:0] t, input logic [15:0] c,
                                        input logic [31:0] v);
        if (t == TYPE_ABS && c == CODE_SLOT)
        begin
            // negative values compare as huge unsigned numbers
            if (v < SLOTS)
                cur_slot = v[2:0];
            else
            begin
                cur_slot = '0;
                wrapped++;
            end
        end
        else if (t == TYPE_ABS && c == CODE_ID)
            slot_id[cur_slot] = v;
        else if (t == TYPE_ABS && c == CODE_X)
            slot_x[cur_slot] = v;
        else if (t == TYPE_ABS && c == CODE_Y)
            slot_y[cur_slot] = v;
        else if (t == TYPE_SYN && c == SYNC_REPORT)
        begin
            reports++;
            queue_frame(1'b0);
        end
        else if (t == TYPE_SYN && c == SYNC_DROPPED)
        begin
            drops++;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_id[i] = ID_EMPTY;
                slot_x[i]  = '0;
                slot_y[i]  = '0;
            end
            queue_frame(1'b1);
        end
        else
            ignored++;
    endfunction

    function automatic void show_word(input string tag, input frame_word_t w);
        $display("  %s slot %0d id %h x %h y %h count %0d drop %0b last %0b",
                 tag, w.slot, w.id, w.x, w.y, w.count, w.drop, w.last);
    endfunction

    // Input driver: one word at a time from the feed, control items in between
    always @(negedge clk)
    begin : feed_events
        feed_item_t item;
        if (rst_n && !(in_valid && !in_fire))
        begin
            if (event_feed.size() != 0 && event_feed[0].kind != KIND_EVENT)
            begin
                item = event_feed[0];
                in_valid <= 1'b0;
                case (item.kind)
                    KIND_MODE:
                    begin
                        send_idle_pct = item.idle_pct;
                        recv_stall_pct <= item.stall_pct;
                        event_feed.delete(0);
                    end
                    KIND_HOLD:
                    begin
                        hold_requests <= hold_requests + 1;
                        event_feed.delete(0);
                    end
                    default:
                    begin
                        // drain: hold off until every frame word is back
                        if (frame_words_due.size() == 0)
                            event_feed.delete(0);
                    end
                endcase
            end
            else if (event_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item = event_feed.pop_front();
                in_valid    <= 1'b1;
                event_type  <= item.ev_type;
                event_code  <= item.ev_code;
                event_value <= item.ev_value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output receiver: random stalls plus a long hold on request
    always @(negedge clk)
    begin : accept_frames
        if (rst_n)
        begin
            if (hold_seen != hold_requests)
            begin
                hold_seen <= hold_requests;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input words, check output words, watchdog
    always @(posedge clk)
    begin : watch_ports
        frame_word_t got;
        frame_word_t want;
        in_fire <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                track_event(event_type, event_code, event_value);
                events_taken++;
            end
            if (out_valid && out_ready)
            begin
                got = {slot_number, finger_id, pos_x, pos_y, active_count, after_drop,
                       frame_last};
                words_checked++;
                if (frame_words_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("frame word %0d arrived with nothing expected", words_checked);
                        show_word("got ", got);
                    end
                end
                else
                begin
                    want = frame_words_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                        begin
                            $display("frame word %0d mismatch", words_checked);
                            show_word("want", want);
                            show_word("got ", got);
                        end
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : run_test
        int          phase;
        int          placed;
        int          n_upd;
        int          pick;
        logic [15:0] code;
        logic [31:0] val;

        cur_slot = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_id[i] = ID_EMPTY;
            slot_x[i]  = '0;
            slot_y[i]  = '0;
        end

        // Directed: empty frame out of reset, field extremes, wrapped selects
        push_event(TYPE_SYN, SYNC_REPORT, '0);
        push_event(TYPE_ABS, CODE_SLOT, 32'd7);
        push_event(TYPE_ABS, CODE_ID, 32'd0);
        push_event(TYPE_ABS, CODE_X, 32'hffff_ffff);
        push_event(TYPE_ABS, CODE_Y, 32'h0);
        push_event(TYPE_ABS, CODE_SLOT, 32'hffff_ffff);
        push_event(TYPE_ABS, CODE_ID, 32'h7fff_ffff);
        push_event(TYPE_ABS, CODE_Y, 32'h8000_0000);
        push_event(TYPE_ABS, CODE_SLOT, 32'd8);
        push_event(TYPE_ABS, CODE_SLOT, 32'd3);
        // released id: most negative value
        push_event(TYPE_ABS, CODE_ID, 32'h8000_0000);
        push_event(TYPE_ABS, CODE_SLOT, 32'h8000_0000);
        push_event(TYPE_ABS, CODE_X, 32'd5);
        push_event(TYPE_SYN, SYNC_REPORT, '0);
        // words that must leave no trace
        push_event(TYPE_SYN, SYN_MT_MARK, '0);
        push_event(TYPE_SYN, 16'hffff, 32'h1234_5678);
        push_event(TYPE_ABS, CODE_OTHER, 32'd77);
        push_event(TYPE_KEY, CODE_ID, 32'd5);
        push_event(16'hffff, 16'hffff, 32'hffff_ffff);
        push_event(TYPE_ABS, CODE_SLOT, 32'd1);
        push_event(TYPE_ABS, CODE_ID, 32'd42);
        // dropped marker clears slots but keeps the selection
        push_event(TYPE_SYN, SYNC_DROPPED, '0);
        push_event(TYPE_SYN, SYNC_REPORT, '0);
        push_event(TYPE_ABS, CODE_ID, 32'd9);
        push_event(TYPE_SYN, SYNC_REPORT, '0);

        // Random phases, each opened after a full drain
        for (phase = 0; phase < 4; phase++)
        begin
            push_ctrl(KIND_DRAIN, 0, 0);
            case (phase)
                0:       push_ctrl(KIND_MODE, 0, 0);
                1:       push_ctrl(KIND_MODE, 51, 0);
                2:       push_ctrl(KIND_MODE, 0, 51);
                default: push_ctrl(KIND_MODE, 30, 30);
            endcase
            if (phase == 0)
            begin
                // long output hold while reports keep coming: input must back up
                push_ctrl(KIND_HOLD, 0, 0);
                for (int k = 0; k < 6; k++)
                begin
                    push_event(TYPE_ABS, CODE_X, $urandom);
                    push_event(TYPE_SYN, SYNC_REPORT, '0);
                end
            end
            placed = 0;
            while (placed < PHASE_EVENTS)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                begin
                    // noise
                    case ($urandom_range(4))
                        0:       push_event(16'($urandom), 16'($urandom), $urandom);
                        1:       push_event(TYPE_ABS, 16'($urandom), $urandom);
                        2:       push_event(TYPE_SYN, SYN_MT_MARK, $urandom);
                        3:       push_event(TYPE_SYN, 16'($urandom), $urandom);
                        default: push_event(TYPE_KEY, CODE_ID, $urandom);
                    endcase
                end
                else
                begin
                    // touch burst: select, a few updates, then usually a sync
                    pick = $urandom_range(99);
                    if (pick < 85)
                        val = $urandom_range(SLOTS - 1);
                    else if (pick < 90)
                        val = SLOTS;
                    else if (pick < 95)
                        val = '1;
                    else
                        val = $urandom;
                    push_event(TYPE_ABS, CODE_SLOT, val);
                    n_upd = $urandom_range(1, 4);
                    for (int k = 0; k < n_upd; k++)
                    begin
                        pick = $urandom_range(2);
                        code = (pick == 0) ? CODE_ID : (pick == 1) ? CODE_X : CODE_Y;
                        pick = $urandom_range(99);
                        if (code == CODE_ID)
                        begin
                            if (pick < 55)
                                val = $urandom_range(1000);
                            else if (pick < 80)
                                val = ID_EMPTY;
                            else if (pick < 85)
                                val = 32'h7fff_ffff;
                            else if (pick < 90)
                                val = 32'h8000_0000;
                            else
                                val = $urandom;
                        end
                        else
                            val = (pick < 70) ? $urandom : $urandom_range(4095);
                        push_event(TYPE_ABS, code, val);
                    end
                    placed += 1 + n_upd;
                    pick = $urandom_range(99);
                    if (pick < 6)
                    begin
                        push_event(TYPE_SYN, SYNC_DROPPED, $urandom);
                        placed++;
                    end
                    else if (pick < 60)
                    begin
                        push_event(TYPE_SYN, SYNC_REPORT, $urandom);
                        placed++;
                    end
                end
            end
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // All words in, all frames back, then a quiet tail
        while (events_taken != events_queued || frame_words_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        mismatches += frame_words_due.size();

        $display("covered %0d events: %0d reports, %0d dropped markers, %0d wrapped selects,",
                 events_taken, reports, drops, wrapped);
        $display("%0d ignored; %0d frame words checked over four idle mixes and a long hold",
                 ignored, words_checked);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule : multitouch_slot_tracker_tb

// ===== sim.f =====
hdl/mst_pkg.sv
hdl/multitouch_slot_tracker.sv
sim/multitouch_slot_tracker_tb.sv
